FILE: rtl/core/psd_pkg.sv
// psd_pkg: widths, case codes and helpers for the point to segment distance block.
// Used by every other file in rtl/core; depends on nothing.
package psd_pkg;

  localparam int CB    = 16;                 // coordinate width
  localparam int DW    = CB + 1;             // signed coordinate difference
  localparam int MW    = DW;                 // difference magnitude
  localparam int PW    = 2 * DW;             // signed product
  localparam int SW    = PW + 1;             // signed sum of two products
  localparam int EPS_W = 16;                 // slope threshold width
  localparam int EW    = EPS_W + MW;         // threshold product
  localparam int QW    = 17;                 // distance width
  localparam int HL    = (SW + 1) / 2;       // low half of |cross|
  localparam int HH    = SW - HL;            // high half of |cross|
  localparam int NW    = 2 * SW;             // squared cross product
  localparam int TW    = SW + QW;            // q * den
  localparam int RW    = (NW > TW + QW) ? NW + 1 : TW + QW + 1;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);
  localparam logic [QW-1:0]    DIST_MAX  = {QW{1'b1}};

  localparam logic [1:0] K_ENDPOINT = 2'd0;
  localparam logic [1:0] K_HORIZ    = 2'd1;
  localparam logic [1:0] K_VERT     = 2'd2;
  localparam logic [1:0] K_FOOT     = 2'd3;

  // |2p - a - b| / 2, saturated to the distance range
  function automatic logic [QW-1:0] half_gap(input logic signed [CB-1:0] p,
                                             input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [CB+1:0] s;
    logic        [CB+1:0] m;
    logic        [CB:0]   h;
    s = ($signed({p, 1'b0}) - (CB+2)'(a)) - (CB+2)'(b);
    m = s[CB+1] ? (CB+2)'(-s) : (CB+2)'(s);
    h = m[CB+1:1];
    half_gap = (h > (CB+1)'(DIST_MAX)) ? DIST_MAX : QW'(h);
  endfunction

endpackage

FILE: rtl/core/psd_if.sv
// psd_in_if / psd_out_if: valid-ready channels for queries and results.
// Depends on psd_pkg.
interface psd_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [psd_pkg::CB-1:0]  point_x;
  logic signed [psd_pkg::CB-1:0]  point_y;
  logic signed [psd_pkg::CB-1:0]  start_x;
  logic signed [psd_pkg::CB-1:0]  start_y;
  logic signed [psd_pkg::CB-1:0]  end_x;
  logic signed [psd_pkg::CB-1:0]  end_y;
  modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  output ready);
endinterface

interface psd_out_if;
  logic                     valid;
  logic                     ready;
  logic [psd_pkg::QW-1:0]   distance;
  logic [1:0]               case_code;
  modport source (output valid, distance, case_code, input ready);
  modport sink   (input valid, distance, case_code, output ready);
endinterface

FILE: rtl/core/point_segment_distance.sv
// point_segment_distance: top level, slope threshold register, front end and root pipeline.
// Each accepted query passes 6 front stages and then 18 root stages to its result.
// Throughput one query per cycle unless out_ch stalls; 17-stage root search sets the depth.
// Reset (synchronous, rst_n low) empties the pipeline and sets slope_epsilon to 66.
// Depends on psd_pkg, psd_if, psd_front, psd_root.
module point_segment_distance (
  input  logic                        clk,
  input  logic                        rst_n,
  psd_in_if.sink                      in_ch,
  psd_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [psd_pkg::EPS_W-1:0]   cfg_wdata
);

  logic [psd_pkg::EPS_W-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= psd_pkg::EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  logic                     f_valid, f_ready;
  logic [psd_pkg::NW-1:0]   f_num;
  logic [psd_pkg::SW-1:0]   f_den;
  logic [psd_pkg::QW-1:0]   f_gap;
  logic [1:0]               f_kind;

  psd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .eps     (eps_r),
    .in_ch   (in_ch),
    .o_valid (f_valid),
    .o_ready (f_ready),
    .o_num   (f_num),
    .o_den   (f_den),
    .o_gap   (f_gap),
    .o_kind  (f_kind)
  );

  psd_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_ready (f_ready),
    .i_num   (f_num),
    .i_den   (f_den),
    .i_gap   (f_gap),
    .i_kind  (f_kind),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/core/psd_front.sv
// psd_front: six-stage geometry front end (differences, products, sums,
// classification, cross squaring, root operand select). Depends on psd_pkg, psd_if.
module psd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [psd_pkg::EPS_W-1:0]     eps,
  psd_in_if.sink                        in_ch,
  output logic                          o_valid,
  input  logic                          o_ready,
  output logic [psd_pkg::NW-1:0]        o_num,
  output logic [psd_pkg::SW-1:0]        o_den,
  output logic [psd_pkg::QW-1:0]        o_gap,
  output logic [1:0]                    o_kind
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || o_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: differences, span tests, half gaps
  logic signed [psd_pkg::DW-1:0] ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic                          xin1_r, yin1_r;
  logic [psd_pkg::QW-1:0]        hgx1_r, hgy1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      ax_r   <= psd_pkg::DW'(in_ch.point_x) - psd_pkg::DW'(in_ch.start_x);
      ay_r   <= psd_pkg::DW'(in_ch.point_y) - psd_pkg::DW'(in_ch.start_y);
      bx_r   <= psd_pkg::DW'(in_ch.point_x) - psd_pkg::DW'(in_ch.end_x);
      by_r   <= psd_pkg::DW'(in_ch.point_y) - psd_pkg::DW'(in_ch.end_y);
      dx_r   <= psd_pkg::DW'(in_ch.end_x) - psd_pkg::DW'(in_ch.start_x);
      dy_r   <= psd_pkg::DW'(in_ch.end_y) - psd_pkg::DW'(in_ch.start_y);
      xin1_r <= !((in_ch.point_x > in_ch.start_x && in_ch.point_x > in_ch.end_x) ||
                  (in_ch.point_x < in_ch.start_x && in_ch.point_x < in_ch.end_x));
      yin1_r <= !((in_ch.point_y > in_ch.start_y && in_ch.point_y > in_ch.end_y) ||
                  (in_ch.point_y < in_ch.start_y && in_ch.point_y < in_ch.end_y));
      hgx1_r <= psd_pkg::half_gap(in_ch.point_x, in_ch.start_x, in_ch.end_x);
      hgy1_r <= psd_pkg::half_gap(in_ch.point_y, in_ch.start_y, in_ch.end_y);
    end
  end

  // stage 2: products
  logic [psd_pkg::MW-1:0]        adx, ady;
  logic signed [psd_pkg::PW-1:0] s1a_r, s1b_r, s2a_r, s2b_r, dda_r, ddb_r;
  logic signed [psd_pkg::PW-1:0] nma_r, nmb_r, cra_r, crb_r;
  logic [psd_pkg::EW-1:0]        epx_r, epy_r;
  logic [psd_pkg::MW-1:0]        adx_r, ady_r;
  logic                          dxz2_r, degen2_r, xin2_r, yin2_r;
  logic [psd_pkg::QW-1:0]        hgx2_r, hgy2_r;

  assign adx = dx_r[psd_pkg::DW-1] ? psd_pkg::MW'(-dx_r) : psd_pkg::MW'(dx_r);
  assign ady = dy_r[psd_pkg::DW-1] ? psd_pkg::MW'(-dy_r) : psd_pkg::MW'(dy_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      s1a_r    <= ax_r * ax_r;
      s1b_r    <= ay_r * ay_r;
      s2a_r    <= bx_r * bx_r;
      s2b_r    <= by_r * by_r;
      dda_r    <= dx_r * dx_r;
      ddb_r    <= dy_r * dy_r;
      nma_r    <= ax_r * dx_r;
      nmb_r    <= ay_r * dy_r;
      cra_r    <= dx_r * ay_r;
      crb_r    <= dy_r * ax_r;
      epx_r    <= psd_pkg::EW'(eps) * psd_pkg::EW'(adx);
      epy_r    <= psd_pkg::EW'(eps) * psd_pkg::EW'(ady);
      adx_r    <= adx;
      ady_r    <= ady;
      dxz2_r   <= (dx_r == '0);
      degen2_r <= (dx_r == '0) && (dy_r == '0);
      xin2_r   <= xin1_r;
      yin2_r   <= yin1_r;
      hgx2_r   <= hgx1_r;
      hgy2_r   <= hgy1_r;
    end
  end

  // stage 3: sums and slope tests
  logic signed [psd_pkg::SW-1:0] d1_r, d2_r, den3_r, num_r, cr_r;
  logic                          horiz_r, vert_r, dxz3_r, degen3_r, xin3_r, yin3_r;
  logic [psd_pkg::QW-1:0]        hgx3_r, hgy3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      d1_r     <= psd_pkg::SW'(s1a_r) + psd_pkg::SW'(s1b_r);
      d2_r     <= psd_pkg::SW'(s2a_r) + psd_pkg::SW'(s2b_r);
      den3_r   <= psd_pkg::SW'(dda_r) + psd_pkg::SW'(ddb_r);
      num_r    <= psd_pkg::SW'(nma_r) + psd_pkg::SW'(nmb_r);
      cr_r     <= psd_pkg::SW'(cra_r) - psd_pkg::SW'(crb_r);
      horiz_r  <= {ady_r, psd_pkg::EPS_W'(0)} < epx_r;
      vert_r   <= {adx_r, psd_pkg::EPS_W'(0)} < epy_r;
      dxz3_r   <= dxz2_r;
      degen3_r <= degen2_r;
      xin3_r   <= xin2_r;
      yin3_r   <= yin2_r;
      hgx3_r   <= hgx2_r;
      hgy3_r   <= hgy2_r;
    end
  end

  // stage 4: classification
  logic [1:0]             kind_nxt;
  logic [psd_pkg::QW-1:0] gap_nxt;
  logic                   foot_ok;

  assign foot_ok = dxz3_r || (!num_r[psd_pkg::SW-1] && num_r <= den3_r);

  always_comb begin
    kind_nxt = psd_pkg::K_ENDPOINT;
    gap_nxt  = hgy3_r;
    if (degen3_r) begin
      kind_nxt = psd_pkg::K_ENDPOINT;
    end else if (horiz_r) begin
      kind_nxt = xin3_r ? psd_pkg::K_HORIZ : psd_pkg::K_ENDPOINT;
    end else if (vert_r) begin
      kind_nxt = yin3_r ? psd_pkg::K_VERT : psd_pkg::K_ENDPOINT;
      gap_nxt  = hgx3_r;
    end else begin
      kind_nxt = foot_ok ? psd_pkg::K_FOOT : psd_pkg::K_ENDPOINT;
    end
  end

  logic [psd_pkg::SW-1:0] near4_r, den4_r, crm_r;
  logic [1:0]             kind4_r;
  logic [psd_pkg::QW-1:0] gap4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      near4_r <= (d2_r < d1_r) ? d2_r : d1_r;
      den4_r  <= den3_r;
      crm_r   <= cr_r[psd_pkg::SW-1] ? psd_pkg::SW'(-cr_r) : psd_pkg::SW'(cr_r);
      kind4_r <= kind_nxt;
      gap4_r  <= gap_nxt;
    end
  end

  // stage 5: split squaring of |cross|
  logic [2*psd_pkg::HH-1:0]         hh_r;
  logic [psd_pkg::HH+psd_pkg::HL-1:0] hl_r;
  logic [2*psd_pkg::HL-1:0]         ll_r;
  logic [psd_pkg::SW-1:0]           near5_r, den5_r;
  logic [1:0]                       kind5_r;
  logic [psd_pkg::QW-1:0]           gap5_r;
  logic [psd_pkg::HH-1:0]           crh;
  logic [psd_pkg::HL-1:0]           crl;

  assign crh = crm_r[psd_pkg::SW-1:psd_pkg::HL];
  assign crl = crm_r[psd_pkg::HL-1:0];

  always_ff @(posedge clk) begin
    if (en5) begin
      hh_r    <= (2*psd_pkg::HH)'(crh) * (2*psd_pkg::HH)'(crh);
      hl_r    <= (psd_pkg::HH+psd_pkg::HL)'(crh) * (psd_pkg::HH+psd_pkg::HL)'(crl);
      ll_r    <= (2*psd_pkg::HL)'(crl) * (2*psd_pkg::HL)'(crl);
      near5_r <= near4_r;
      den5_r  <= den4_r;
      kind5_r <= kind4_r;
      gap5_r  <= gap4_r;
    end
  end

  // stage 6: root operands
  logic [psd_pkg::NW-1:0] crsq;
  assign crsq = (psd_pkg::NW'(hh_r) << (2*psd_pkg::HL)) +
                (psd_pkg::NW'(hl_r) << (psd_pkg::HL+1)) + psd_pkg::NW'(ll_r);

  logic [psd_pkg::NW-1:0] num6_r;
  logic [psd_pkg::SW-1:0] den6_r;
  logic [1:0]             kind6_r;
  logic [psd_pkg::QW-1:0] gap6_r;

  always_ff @(posedge clk) begin
    if (en6) begin
      case (kind5_r)
        psd_pkg::K_FOOT: begin
          num6_r <= crsq;
          den6_r <= den5_r;
        end
        psd_pkg::K_ENDPOINT: begin
          num6_r <= psd_pkg::NW'(near5_r);
          den6_r <= psd_pkg::SW'(1);
        end
        default: begin
          num6_r <= '0;
          den6_r <= psd_pkg::SW'(1);
        end
      endcase
      kind6_r <= kind5_r;
      gap6_r  <= gap5_r;
    end
  end

  assign o_valid = v6_r;
  assign o_num   = num6_r;
  assign o_den   = den6_r;
  assign o_gap   = gap6_r;
  assign o_kind  = kind6_r;

endmodule

FILE: rtl/core/psd_root.sv
// psd_root: one-bit-per-stage pipelined search for the largest q with q*q*den <= num,
// ending in the output register. Depends on psd_pkg, psd_if.
module psd_root (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      i_valid,
  output logic                      i_ready,
  input  logic [psd_pkg::NW-1:0]    i_num,
  input  logic [psd_pkg::SW-1:0]    i_den,
  input  logic [psd_pkg::QW-1:0]    i_gap,
  input  logic [1:0]                i_kind,
  psd_out_if.source                 out_ch
);

  localparam int N = psd_pkg::QW;

  logic                       v_r    [N+1];
  logic [N:0]                 en;
  logic [psd_pkg::RW-1:0]     rem_r  [N+1];
  logic [psd_pkg::TW-1:0]     t_r    [N+1];
  logic [psd_pkg::QW-1:0]     q_r    [N+1];
  logic [psd_pkg::SW-1:0]     d_r    [N+1];
  logic [psd_pkg::QW-1:0]     gap_r  [N+1];
  logic [1:0]                 kind_r [N+1];

  always_comb begin
    en[N] = !v_r[N] || out_ch.ready;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign i_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= psd_pkg::RW'(i_num);
      t_r[0]    <= '0;
      q_r[0]    <= '0;
      d_r[0]    <= i_den;
      gap_r[0]  <= i_gap;
      kind_r[0] <= i_kind;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_bit
    localparam int B = N - k;
    logic [psd_pkg::RW-1:0] inc;
    logic                   take;
    logic [psd_pkg::RW-1:0] rem_nxt;
    logic [psd_pkg::TW-1:0] t_nxt;
    logic [psd_pkg::QW-1:0] q_nxt;

    assign inc     = (psd_pkg::RW'(t_r[k-1]) << (B + 1)) +
                     (psd_pkg::RW'(d_r[k-1]) << (2 * B));
    assign take    = inc <= rem_r[k-1];
    assign rem_nxt = take ? rem_r[k-1] - inc : rem_r[k-1];
    assign t_nxt   = take ? t_r[k-1] + (psd_pkg::TW'(d_r[k-1]) << B) : t_r[k-1];
    assign q_nxt   = take ? q_r[k-1] | (psd_pkg::QW'(1) << B) : q_r[k-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        t_r[k]    <= t_nxt;
        q_r[k]    <= q_nxt;
        d_r[k]    <= d_r[k-1];
        gap_r[k]  <= gap_r[k-1];
        kind_r[k] <= kind_r[k-1];
      end
    end
  end

  logic bypass;
  assign bypass = (kind_r[N] == psd_pkg::K_HORIZ) || (kind_r[N] == psd_pkg::K_VERT);

  assign out_ch.valid     = v_r[N];
  assign out_ch.distance  = bypass ? gap_r[N] : q_r[N];
  assign out_ch.case_code = kind_r[N];

  // span cases carry a zero numerator, so the search must yield zero
  a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N] && bypass |-> q_r[N] == '0)
    else $error("span case produced a non-zero root");

  // endpoint distance is a plain square root
  a_end_unit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && kind_r[0] == psd_pkg::K_ENDPOINT |-> d_r[0] == psd_pkg::SW'(1))
    else $error("endpoint transaction with non-unit denominator");

  // a foot case never has a zero denominator
  a_foot_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && kind_r[0] == psd_pkg::K_FOOT |-> d_r[0] != '0)
    else $error("foot transaction with zero denominator");

  // the remainder never exceeds the numerator it started from
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && en[1] && v_r[0] |=> rem_r[1] <= $past(rem_r[0]))
    else $error("root remainder grew");

endmodule
